>>> rtl/bca_pkg.sv
// Shared types and constants for the bitmap chunk allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package bca_pkg;

   localparam int MAX_CHUNKS  = 1024;
   localparam int WORD_BITS   = 32;
   localparam int NUM_WORDS   = MAX_CHUNKS / WORD_BITS;
   localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int CHUNK_IDX_W = $clog2(MAX_CHUNKS);
   localparam int CNT_W       = CHUNK_IDX_W + 1;

   localparam int UNIT_W   = 32;
   localparam int SHIFT_W  = 5;
   localparam int MAP_W    = 11;
   localparam int COUNT_W  = 27;
   localparam int NEED_W   = COUNT_W + 1;
   localparam int PADDR_W  = 4;

   localparam logic [1:0] REG_BASE_UNIT   = 2'd0;
   localparam logic [1:0] REG_CHUNK_SHIFT = 2'd1;
   localparam logic [1:0] REG_MAP_CHUNKS  = 2'd2;

   typedef enum logic [2:0] {
      FN_ALLOC      = 3'd0,
      FN_SEQUENTIAL = 3'd1,
      FN_BEST_FIT   = 3'd2,
      FN_TAKE       = 3'd3,
      FN_FREE       = 3'd4,
      FN_QUERY      = 3'd5,
      FN_HIGHEST    = 3'd6,
      FN_UNUSED     = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_NOSPACE = 3'd1,
      STAT_BADTAKE = 3'd2,
      STAT_BADFREE = 3'd3,
      STAT_NONE    = 3'd4
   } stat_type;

   typedef enum logic [1:0] {
      RES_ZERO  = 2'd0,
      RES_GRANT = 2'd1,
      RES_TOP   = 2'd2
   } res_sel_type;

   typedef enum logic [3:0] {
      DP_NOP, DP_LOAD, DP_PREP, DP_INIT_UP, DP_INIT_DOWN, DP_STEP_UP, DP_STEP_DOWN,
      DP_BEST_STEP, DP_GOT_RUN, DP_GOT_DOWN, DP_GOT_BEST, DP_SET_GOT, DP_SET_SC,
      DP_MARK, DP_CHECK_STEP, DP_FREE
   } dp_op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_DECIDE, S_FIRST, S_HIGHFREE, S_BEST, S_BEST_END, S_MARK_SETUP,
      S_MARK, S_TCHECK, S_FREE, S_QUERY, S_HIGHEST, S_DONE
   } state_type;

   typedef struct packed {
      logic [UNIT_W-1:0]  base_unit;
      logic [SHIFT_W-1:0] chunk_shift;
      logic [MAP_W-1:0]   map_chunks;
   } cfg_type;

   typedef struct packed {
      dp_op_type   op;
      logic        probe_down;
      logic        res_load;
      res_sel_type res_sel;
      stat_type    res_status;
      logic        res_taken;
   } cmd_type;

   typedef struct packed {
      logic base_ok;
      logic need_zero;
      logic need_one;
      logic need_gt_n;
      logic lim_over;
      logic sc_lt_n;
      logic avail;
      logic run_hit;
      logic c_zero;
      logic c_eq_n;
      logic rem_zero;
      logic best_valid;
   } dp_stat_type;

endpackage

>>> rtl/bca_ctrl.sv
// Controller state machine of the bitmap chunk allocator.
// Depends on bca_pkg; drives the datapath through cmd_type commands.
module bca_ctrl import bca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  req_func,
   input  dp_stat_type stat,
   output cmd_type     cmd,
   output logic        busy,
   output logic        rsp_valid
);

   state_type   state_ff, state_in;
   func_type    func_ff, func_in;
   stat_type    st_ff, st_in;
   res_sel_type sel_ff, sel_in;
   logic        taken_ff, taken_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff  <= func_in;
      st_ff    <= st_in;
      sel_ff   <= sel_in;
      taken_ff <= taken_in;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      st_in        = st_ff;
      sel_in       = sel_ff;
      taken_in     = taken_ff;
      rsp_valid_in = 1'b0;
      cmd            = '0;
      cmd.op         = DP_NOP;
      cmd.res_sel    = sel_ff;
      cmd.res_status = st_ff;
      cmd.res_taken  = taken_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = DP_LOAD;
               func_in  = func_type'(req_func);
               st_in    = STAT_OK;
               sel_in   = RES_ZERO;
               taken_in = 1'b0;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.op   = DP_PREP;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            unique case (func_ff)
               FN_ALLOC, FN_SEQUENTIAL, FN_BEST_FIT: begin
                  priority if (stat.need_one) begin
                     if (func_ff == FN_SEQUENTIAL) begin
                        cmd.op   = DP_INIT_UP;
                        state_in = S_FIRST;
                     end else begin
                        cmd.op   = DP_INIT_DOWN;
                        state_in = S_HIGHFREE;
                     end
                  end else if (stat.need_zero || stat.need_gt_n) begin
                     st_in    = STAT_NOSPACE;
                     state_in = S_DONE;
                  end else begin
                     cmd.op   = DP_INIT_UP;
                     state_in = (func_ff == FN_BEST_FIT) ? S_BEST : S_FIRST;
                  end
               end
               FN_TAKE: begin
                  priority if (!stat.base_ok || (!stat.need_zero && stat.lim_over)) begin
                     st_in    = STAT_BADTAKE;
                     state_in = S_DONE;
                  end else if (stat.need_zero) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.op   = DP_SET_SC;
                     state_in = S_TCHECK;
                  end
               end
               FN_FREE: begin
                  if (!stat.base_ok || stat.lim_over) begin
                     st_in    = STAT_BADFREE;
                     state_in = S_DONE;
                  end else begin
                     cmd.op   = DP_SET_SC;
                     state_in = S_FREE;
                  end
               end
               FN_QUERY: begin
                  cmd.op   = DP_SET_SC;
                  state_in = S_QUERY;
               end
               FN_HIGHEST: begin
                  cmd.op   = DP_INIT_DOWN;
                  state_in = S_HIGHEST;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_FIRST: begin
            priority if (stat.c_eq_n) begin
               st_in    = STAT_NOSPACE;
               state_in = S_DONE;
            end else if (stat.run_hit) begin
               cmd.op   = DP_GOT_RUN;
               state_in = S_MARK_SETUP;
            end else begin
               cmd.op = DP_STEP_UP;
            end
         end
         S_HIGHFREE: begin
            cmd.probe_down = 1'b1;
            priority if (stat.c_zero) begin
               st_in    = STAT_NOSPACE;
               state_in = S_DONE;
            end else if (stat.avail) begin
               cmd.op   = DP_GOT_DOWN;
               state_in = S_MARK_SETUP;
            end else begin
               cmd.op = DP_STEP_DOWN;
            end
         end
         S_BEST: begin
            // the cycle at c == n closes the last run
            cmd.op = DP_BEST_STEP;
            if (stat.c_eq_n) state_in = S_BEST_END;
         end
         S_BEST_END: begin
            if (stat.best_valid) begin
               cmd.op   = DP_GOT_BEST;
               state_in = S_MARK_SETUP;
            end else begin
               st_in    = STAT_NOSPACE;
               state_in = S_DONE;
            end
         end
         S_MARK_SETUP: begin
            cmd.op   = DP_SET_GOT;
            sel_in   = RES_GRANT;
            state_in = S_MARK;
         end
         S_MARK: begin
            if (stat.rem_zero) state_in = S_DONE;
            else cmd.op = DP_MARK;
         end
         S_TCHECK: begin
            priority if (stat.rem_zero) begin
               cmd.op   = DP_SET_SC;
               state_in = S_MARK;
            end else if (!stat.avail) begin
               st_in    = STAT_BADTAKE;
               state_in = S_DONE;
            end else begin
               cmd.op = DP_CHECK_STEP;
            end
         end
         S_FREE: begin
            priority if (stat.rem_zero) begin
               state_in = S_DONE;
            end else if (stat.avail) begin
               st_in    = STAT_BADFREE;
               state_in = S_DONE;
            end else begin
               cmd.op = DP_FREE;
            end
         end
         S_QUERY: begin
            taken_in = stat.base_ok && !(stat.sc_lt_n && stat.avail);
            state_in = S_DONE;
         end
         S_HIGHEST: begin
            cmd.probe_down = 1'b1;
            priority if (stat.c_zero) begin
               st_in    = STAT_NONE;
               state_in = S_DONE;
            end else if (!stat.avail) begin
               sel_in   = RES_TOP;
               state_in = S_DONE;
            end else begin
               cmd.op = DP_STEP_DOWN;
            end
         end
         S_DONE: begin
            cmd.res_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/bca_datapath.sv
// Datapath of the bitmap chunk allocator: free map, chunk cursor, run
// tracking and result registers. Depends on bca_pkg.
module bca_datapath import bca_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  cfg_type             cfg,
   input  logic [UNIT_W-1:0]   req_start_unit,
   input  logic [COUNT_W-1:0]  req_unit_count,
   output dp_stat_type         stat,
   output logic [UNIT_W-1:0]   rsp_result_unit,
   output logic                rsp_is_taken,
   output logic [2:0]          rsp_status
);

   logic [WORD_BITS-1:0]   free_ff [NUM_WORDS];
   logic [UNIT_W-1:0]      start_ff;
   logic [COUNT_W-1:0]     units_ff;
   logic [NEED_W-1:0]      need_ff;
   logic [UNIT_W-1:0]      sc_ff;
   logic                   base_ok_ff;
   logic [CNT_W-1:0]       c_ff, run_ff, rem_ff, s_ff, blen_ff;
   logic [CHUNK_IDX_W-1:0] got_ff, best_ff;
   logic                   bvalid_ff;
   logic [UNIT_W-1:0]      res_unit_ff;
   logic                   res_taken_ff;
   logic [2:0]             res_status_ff;

   logic [CNT_W-1:0]       n;
   logic [UNIT_W:0]        round_sum;
   logic [UNIT_W:0]        mask;
   logic [CNT_W-1:0]       probe;
   logic                   bit_free;
   logic [CNT_W:0]         run_next;
   logic [UNIT_W:0]        lim;
   logic                   write_en, write_val;

   assign n = ({{(CNT_W-1){1'b0}}, 1'b0} | CNT_W'(cfg.map_chunks)) > CNT_W'(MAX_CHUNKS)
            ? CNT_W'(MAX_CHUNKS) : CNT_W'(cfg.map_chunks);

   assign mask      = ((UNIT_W+1)'(1) << cfg.chunk_shift) - (UNIT_W+1)'(1);
   assign round_sum = (UNIT_W+1)'(units_ff) + mask;
   assign lim       = (UNIT_W+1)'(sc_ff) + (UNIT_W+1)'(need_ff);

   assign probe    = cmd.probe_down ? c_ff - CNT_W'(1) : c_ff;
   assign bit_free = (probe < n) &&
      free_ff[probe[CHUNK_IDX_W-1:BIT_IDX_W]][probe[BIT_IDX_W-1:0]];
   assign run_next = (CNT_W+1)'(run_ff) + (CNT_W+1)'(1);

   assign stat.base_ok    = base_ok_ff;
   assign stat.need_zero  = (need_ff == '0);
   assign stat.need_one   = (need_ff == NEED_W'(1));
   assign stat.need_gt_n  = need_ff > NEED_W'(n);
   assign stat.lim_over   = lim > (UNIT_W+1)'(n);
   assign stat.sc_lt_n    = sc_ff < UNIT_W'(n);
   assign stat.avail      = bit_free;
   assign stat.run_hit    = bit_free && (NEED_W'(run_next) >= need_ff);
   assign stat.c_zero     = (c_ff == '0);
   assign stat.c_eq_n     = (c_ff >= n);
   assign stat.rem_zero   = (rem_ff == '0);
   assign stat.best_valid = bvalid_ff;

   always_comb begin
      write_en  = 1'b0;
      write_val = 1'b0;
      unique case (cmd.op)
         DP_MARK: write_en = 1'b1;
         DP_FREE: begin
            write_en  = 1'b1;
            write_val = 1'b1;
         end
         default: write_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORDS; i++) free_ff[i] <= '1;
      end else if (write_en) begin
         free_ff[c_ff[CHUNK_IDX_W-1:BIT_IDX_W]][c_ff[BIT_IDX_W-1:0]] <= write_val;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         DP_LOAD: begin
            start_ff <= req_start_unit;
            units_ff <= req_unit_count;
         end
         DP_PREP: begin
            need_ff    <= NEED_W'(round_sum >> cfg.chunk_shift);
            sc_ff      <= (start_ff - cfg.base_unit) >> cfg.chunk_shift;
            base_ok_ff <= (start_ff >= cfg.base_unit);
         end
         DP_INIT_UP: begin
            c_ff      <= '0;
            run_ff    <= '0;
            bvalid_ff <= 1'b0;
         end
         DP_INIT_DOWN: c_ff <= n;
         DP_STEP_UP: begin
            run_ff <= bit_free ? CNT_W'(run_next) : '0;
            c_ff   <= c_ff + CNT_W'(1);
         end
         DP_STEP_DOWN: c_ff <= c_ff - CNT_W'(1);
         DP_BEST_STEP: begin
            if (bit_free) begin
               if (run_ff == '0) s_ff <= c_ff;
               run_ff <= CNT_W'(run_next);
            end else begin
               if ((NEED_W'(run_ff) >= need_ff) && (!bvalid_ff || run_ff < blen_ff)) begin
                  best_ff   <= s_ff[CHUNK_IDX_W-1:0];
                  blen_ff   <= run_ff;
                  bvalid_ff <= 1'b1;
               end
               run_ff <= '0;
            end
            if (c_ff < n) c_ff <= c_ff + CNT_W'(1);
         end
         DP_GOT_RUN:  got_ff <= CHUNK_IDX_W'(c_ff - run_ff);
         DP_GOT_DOWN: got_ff <= CHUNK_IDX_W'(c_ff - CNT_W'(1));
         DP_GOT_BEST: got_ff <= best_ff;
         DP_SET_GOT: begin
            c_ff   <= CNT_W'(got_ff);
            rem_ff <= CNT_W'(need_ff);
         end
         DP_SET_SC: begin
            c_ff   <= CNT_W'(sc_ff);
            rem_ff <= CNT_W'(need_ff);
         end
         DP_MARK, DP_CHECK_STEP, DP_FREE: begin
            c_ff   <= c_ff + CNT_W'(1);
            rem_ff <= rem_ff - CNT_W'(1);
         end
         default: c_ff <= c_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         unique case (cmd.res_sel)
            RES_GRANT: res_unit_ff <= cfg.base_unit + (UNIT_W'(got_ff) << cfg.chunk_shift);
            RES_TOP:   res_unit_ff <= cfg.base_unit + (UNIT_W'(c_ff) << cfg.chunk_shift)
                                      - UNIT_W'(1);
            default:   res_unit_ff <= '0;
         endcase
         res_taken_ff  <= cmd.res_taken;
         res_status_ff <= cmd.res_status;
      end
   end

   assign rsp_result_unit = res_unit_ff;
   assign rsp_is_taken    = res_taken_ff;
   assign rsp_status      = res_status_ff;

endmodule

>>> rtl/bitmap_chunk_allocator_top.sv
// Top level of the bitmap chunk allocator: register port, controller and datapath.
// Depends on bca_pkg, bca_ctrl and bca_datapath.

// A request is taken when start is high and busy is low; its single result
// appears with rsp_valid high for one cycle and cannot be held off. The map is
// walked one chunk per cycle by the datapath cursor. A request is loaded and
// prepared, a search or a highest scan walks the map, then each chunk is marked,
// checked or freed in turn, a closing step ends the marking, and the result is
// loaded. The worst case is a best fit that marks the whole map. Queries and
// zero-length requests finish without a walk, as do errors found when the
// request is decided.
module bitmap_chunk_allocator_top import bca_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_func,
   input  logic [UNIT_W-1:0]   req_start_unit,
   input  logic [COUNT_W-1:0]  req_unit_count,
   output logic                rsp_valid,
   output logic [UNIT_W-1:0]   rsp_result_unit,
   output logic                rsp_is_taken,
   output logic [2:0]          rsp_status,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   cfg_type     cfg_ff, cfg_in;
   cmd_type     cmd;
   dp_stat_type stat;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_BASE_UNIT:   cfg_in.base_unit   = pwdata;
            REG_CHUNK_SHIFT: cfg_in.chunk_shift = pwdata[SHIFT_W-1:0];
            REG_MAP_CHUNKS:  cfg_in.map_chunks  = pwdata[MAP_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_unit   <= '0;
         cfg_ff.chunk_shift <= '0;
         cfg_ff.map_chunks  <= MAP_W'(MAX_CHUNKS);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_BASE_UNIT:   prdata = cfg_ff.base_unit;
         REG_CHUNK_SHIFT: prdata = 32'(cfg_ff.chunk_shift);
         REG_MAP_CHUNKS:  prdata = 32'(cfg_ff.map_chunks);
         default:         prdata = '0;
      endcase
   end

   bca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_func),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bca_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg_ff),
      .req_start_unit  (req_start_unit),
      .req_unit_count  (req_unit_count),
      .stat            (stat),
      .rsp_result_unit (rsp_result_unit),
      .rsp_is_taken    (rsp_is_taken),
      .rsp_status      (rsp_status)
   );

endmodule
